FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock outside reset
`define VDPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define VDPC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define VDPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/vdpc_pkg.sv
`timescale 1ns / 1ps

package vdpc_pkg;

    // field and register widths
    localparam int C_TICK_W     = 1;
    localparam int C_STEP_W     = 9;
    localparam int C_LIMIT_W    = 12;
    localparam int C_DEBOUNCE_W = 10;
    localparam int C_K_W        = 16;
    localparam int C_TARGET_W   = 13;
    localparam int C_POURED_W   = 16;
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 16;

    // default sizes of the counters
    localparam int C_PULSE_BITS   = 20;
    localparam int C_ELAPSED_BITS = 16;

    // configuration register indexes
    localparam logic [C_CFG_IDX_W-1:0] C_REG_STEP     = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_MIN      = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_MAX      = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_DEBOUNCE = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_K        = 3'd4;

    // reset values
    localparam logic [C_STEP_W-1:0]     C_STEP_RST     = 9'd50;
    localparam logic [C_LIMIT_W-1:0]    C_MIN_RST      = 12'd50;
    localparam logic [C_LIMIT_W-1:0]    C_MAX_RST      = 12'd300;
    localparam logic [C_DEBOUNCE_W-1:0] C_DEBOUNCE_RST = 10'd50;
    localparam logic [C_K_W-1:0]        C_K_RST        = 16'd2222;
    localparam logic [C_TARGET_W-1:0]   C_TARGET_RST   = 13'd200;

    // microlitres to millilitres
    localparam int C_VOL_SCALE = 1000;

    // target scaled to microlitres, 8191 * 1000 fits in 23 bits
    localparam int C_TGT_UL_W = 23;
    localparam logic [C_TGT_UL_W-1:0] C_TGT_UL_RST = C_TGT_UL_W'(200 * C_VOL_SCALE);

    // poured volume saturates once the product reaches 65536 ml
    localparam int C_VOL_IN_W = 26;
    localparam logic [C_VOL_IN_W-1:0] C_POUR_SAT_UL = C_VOL_IN_W'(65536 * C_VOL_SCALE);

    // divide by 1000 through a reciprocal, exact for inputs below 2^26
    localparam int C_RECIP_W     = 27;
    localparam int C_RECIP_SHIFT = 36;
    localparam logic [C_RECIP_W-1:0] C_RECIP = 27'd68719477;
    localparam int C_DIV_PROD_W  = C_VOL_IN_W + C_RECIP_W;

    // one result item
    typedef struct packed {
        logic                  pump_on;
        logic [C_TARGET_W-1:0] target_ml;
        logic [C_POURED_W-1:0] dosed_ml;
        logic                  finished;
    } t_result;

endpackage

FILE: src/volume_dosing_pump_controller.sv
`timescale 1ns / 1ps
// Volume dosing pump controller.
// Input channel (i_valid / o_ready) carries one pin sample per transfer: the
// millisecond tick, the raw up and down button levels, the start edge and the
// flow meter pulse edge. Output channel (o_valid / i_ready) returns exactly one
// result per sample: pump drive, target volume, poured volume and finish flag.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) that
// takes effect on the clock edge; write it only while no sample is in flight.
// Each result is registered before o_valid. Throughput is one sample per
// cycle while o_ready is high: all state updates for a sample happen in the
// cycle it is accepted, and the poured volume comes from a running pulse*k
// product that is divided by 1000 through one reciprocal multiplier before
// the result register. A k factor write reloads that product and its next
// step with two multiplies.
// Behind the result register sits a one-entry skid register, so a sample is
// still accepted while a result waits; o_ready drops only when both are full.
// Synchronous reset (i_rst_n low) restores the default registers, idle state,
// target 200 ml, zero pulses, and empties the output registers.
module volume_dosing_pump_controller #(
    parameter int PULSE_BITS   = vdpc_pkg::C_PULSE_BITS,
    parameter int ELAPSED_BITS = vdpc_pkg::C_ELAPSED_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [vdpc_pkg::C_CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vdpc_pkg::C_CFG_DATA_W-1:0]   i_cfg_data,
    // sample channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_ms_tick,
    input  logic                                i_up_level,
    input  logic                                i_down_level,
    input  logic                                i_start_edge,
    input  logic                                i_flow_pulse,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_pump_on,
    output logic [vdpc_pkg::C_TARGET_W-1:0]     o_target_ml,
    output logic [vdpc_pkg::C_POURED_W-1:0]     o_dosed_ml,
    output logic                                o_finished
);

`include "assert_macros.svh"

    localparam int PROD_W = PULSE_BITS + vdpc_pkg::C_K_W;
    localparam logic [PULSE_BITS-1:0]   PULSE_MAX   = {PULSE_BITS{1'b1}};
    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

    // configuration registers
    logic [vdpc_pkg::C_STEP_W-1:0]     r_step;
    logic [vdpc_pkg::C_LIMIT_W-1:0]    r_min;
    logic [vdpc_pkg::C_LIMIT_W-1:0]    r_max;
    logic [vdpc_pkg::C_DEBOUNCE_W-1:0] r_debounce;
    logic [vdpc_pkg::C_K_W-1:0]        r_k;

    // controller state
    logic                                r_pouring;
    logic [vdpc_pkg::C_TARGET_W-1:0]     r_target;
    logic [vdpc_pkg::C_TGT_UL_W-1:0]     r_tgt_ul;
    logic [PULSE_BITS-1:0]               r_pulse;
    logic [PROD_W-1:0]                   r_prod;
    logic [PROD_W-1:0]                   r_prod_inc;
    logic                                r_up_last;
    logic                                r_down_last;
    logic [ELAPSED_BITS-1:0]             r_up_el;
    logic [ELAPSED_BITS-1:0]             r_down_el;
    logic [ELAPSED_BITS-1:0]             r_start_el;

    // output and skid registers
    logic                  r_out_valid;
    vdpc_pkg::t_result     r_out;
    logic                  r_skid_valid;
    vdpc_pkg::t_result     r_skid;

    // next-state values
    logic                                n_pouring;
    logic [vdpc_pkg::C_TARGET_W-1:0]     n_target;
    logic [vdpc_pkg::C_TGT_UL_W-1:0]     n_tgt_ul;
    logic [PULSE_BITS-1:0]               n_pulse;
    logic [PROD_W-1:0]                   n_prod;
    logic [PROD_W-1:0]                   n_prod_inc;
    logic [ELAPSED_BITS-1:0]             n_up_el;
    logic [ELAPSED_BITS-1:0]             n_down_el;
    logic [ELAPSED_BITS-1:0]             n_start_el;
    vdpc_pkg::t_result                   n_result;

    logic                                in_xfer;
    logic                                out_xfer;
    logic                                pulse_inc;
    logic                                start_hit;
    logic                                up_hit;
    logic                                down_hit;
    logic                                pour_after_start;
    logic                                pulse_clear;
    logic                                done;
    logic [ELAPSED_BITS-1:0]             debounce_ext;
    logic [ELAPSED_BITS-1:0]             tick_up_el;
    logic [ELAPSED_BITS-1:0]             tick_down_el;
    logic [ELAPSED_BITS-1:0]             tick_start_el;
    logic [vdpc_pkg::C_TARGET_W-1:0]     step_ext;
    logic [vdpc_pkg::C_TARGET_W-1:0]     tgt_after_up;
    logic [vdpc_pkg::C_DIV_PROD_W-1:0]   div_prod;
    logic [vdpc_pkg::C_POURED_W-1:0]     poured;
    logic [PULSE_BITS:0]                 pulse_p1;
    logic [PROD_W-1:0]                   cfg_k_ext;

    // handshake
    assign o_ready  = !r_skid_valid;
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_out_valid && i_ready;

    // saturating millisecond counters
    assign debounce_ext = ELAPSED_BITS'(r_debounce);
    assign tick_up_el    = (i_ms_tick && r_up_el != ELAPSED_MAX) ?
                           r_up_el + ELAPSED_BITS'(1) : r_up_el;
    assign tick_down_el  = (i_ms_tick && r_down_el != ELAPSED_MAX) ?
                           r_down_el + ELAPSED_BITS'(1) : r_down_el;
    assign tick_start_el = (i_ms_tick && r_start_el != ELAPSED_MAX) ?
                           r_start_el + ELAPSED_BITS'(1) : r_start_el;

    // debounced start toggle
    assign start_hit        = i_start_edge && (tick_start_el > debounce_ext);
    assign pour_after_start = start_hit ? !r_pouring : r_pouring;
    assign pulse_clear      = start_hit && !r_pouring;
    assign n_start_el       = start_hit ? '0 : tick_start_el;

    // flow pulse count and the running pulse*k product
    assign pulse_inc = i_flow_pulse && (r_pulse != PULSE_MAX);
    always_comb begin
        if (pulse_clear) begin
            n_pulse    = '0;
            n_prod     = '0;
            n_prod_inc = PROD_W'(r_k);
        end else if (pulse_inc) begin
            n_pulse    = r_pulse + PULSE_BITS'(1);
            n_prod     = r_prod_inc;
            n_prod_inc = r_prod_inc + PROD_W'(r_k);
        end else begin
            n_pulse    = r_pulse;
            n_prod     = r_prod;
            n_prod_inc = r_prod_inc;
        end
    end

    // up then down button, falling edge after debounce
    assign step_ext     = vdpc_pkg::C_TARGET_W'(r_step);
    assign up_hit       = !i_up_level && r_up_last && (tick_up_el > debounce_ext);
    assign down_hit     = !i_down_level && r_down_last && (tick_down_el > debounce_ext);
    assign n_up_el      = up_hit ? '0 : tick_up_el;
    assign n_down_el    = down_hit ? '0 : tick_down_el;
    assign tgt_after_up = (up_hit && !pour_after_start &&
                           r_target < vdpc_pkg::C_TARGET_W'(r_max)) ?
                          r_target + step_ext : r_target;
    always_comb begin
        if (down_hit && !pour_after_start &&
            tgt_after_up > vdpc_pkg::C_TARGET_W'(r_min)) begin
            n_target = (tgt_after_up > step_ext) ? tgt_after_up - step_ext : '0;
        end else begin
            n_target = tgt_after_up;
        end
    end
    assign n_tgt_ul = vdpc_pkg::C_TGT_UL_W'(n_target) *
                      vdpc_pkg::C_TGT_UL_W'(vdpc_pkg::C_VOL_SCALE);

    // completion: target only moves while idle, so the stored scaled target holds
    assign done      = pour_after_start && (n_prod >= PROD_W'(r_tgt_ul));
    assign n_pouring = pour_after_start && !done;

    // poured ml = floor(product / 1000), saturated
    assign div_prod = vdpc_pkg::C_DIV_PROD_W'(n_prod[vdpc_pkg::C_VOL_IN_W-1:0]) *
                      vdpc_pkg::C_DIV_PROD_W'(vdpc_pkg::C_RECIP);
    assign poured   = (n_prod >= PROD_W'(vdpc_pkg::C_POUR_SAT_UL)) ?
                      {vdpc_pkg::C_POURED_W{1'b1}} :
                      div_prod[vdpc_pkg::C_RECIP_SHIFT +: vdpc_pkg::C_POURED_W];

    always_comb begin
        n_result.pump_on   = n_pouring;
        n_result.target_ml = n_target;
        n_result.dosed_ml  = poured;
        n_result.finished  = done;
    end

    // reload of the product when k changes
    assign pulse_p1  = {1'b0, r_pulse} + (PULSE_BITS + 1)'(1);
    assign cfg_k_ext = PROD_W'(i_cfg_data[vdpc_pkg::C_K_W-1:0]);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= vdpc_pkg::C_STEP_RST;
            r_min      <= vdpc_pkg::C_MIN_RST;
            r_max      <= vdpc_pkg::C_MAX_RST;
            r_debounce <= vdpc_pkg::C_DEBOUNCE_RST;
            r_k        <= vdpc_pkg::C_K_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vdpc_pkg::C_REG_STEP:     r_step     <= i_cfg_data[vdpc_pkg::C_STEP_W-1:0];
                vdpc_pkg::C_REG_MIN:      r_min      <= i_cfg_data[vdpc_pkg::C_LIMIT_W-1:0];
                vdpc_pkg::C_REG_MAX:      r_max      <= i_cfg_data[vdpc_pkg::C_LIMIT_W-1:0];
                vdpc_pkg::C_REG_DEBOUNCE: r_debounce <= i_cfg_data[vdpc_pkg::C_DEBOUNCE_W-1:0];
                vdpc_pkg::C_REG_K:        r_k        <= i_cfg_data[vdpc_pkg::C_K_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // controller state, updated once per accepted sample; a k write reloads the product instead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pouring   <= 1'b0;
            r_target    <= vdpc_pkg::C_TARGET_RST;
            r_tgt_ul    <= vdpc_pkg::C_TGT_UL_RST;
            r_pulse     <= '0;
            r_prod      <= '0;
            r_prod_inc  <= PROD_W'(vdpc_pkg::C_K_RST);
            r_up_last   <= 1'b1;
            r_down_last <= 1'b1;
            r_up_el     <= '0;
            r_down_el   <= '0;
            r_start_el  <= '0;
        end else if (i_cfg_we && i_cfg_idx == vdpc_pkg::C_REG_K) begin
            r_prod     <= PROD_W'(r_pulse) * cfg_k_ext;
            r_prod_inc <= PROD_W'(pulse_p1) * cfg_k_ext;
        end else if (in_xfer) begin
            r_pouring   <= n_pouring;
            r_target    <= n_target;
            r_tgt_ul    <= n_tgt_ul;
            r_pulse     <= n_pulse;
            r_prod      <= n_prod;
            r_prod_inc  <= n_prod_inc;
            r_up_last   <= i_up_level;
            r_down_last <= i_down_level;
            r_up_el     <= n_up_el;
            r_down_el   <= n_down_el;
            r_start_el  <= n_start_el;
        end
    end

    // result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_xfer) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_xfer) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (in_xfer && r_out_valid && !out_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pump_on   = r_out.pump_on;
    assign o_target_ml = r_out.target_ml;
    assign o_dosed_ml  = r_out.dosed_ml;
    assign o_finished  = r_out.finished;

    // checks
    `VDPC_ASSERT_IMPLY(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid entry holds a result while the output register is empty")
    `VDPC_ASSERT(a_prod_step, r_prod_inc == r_prod + PROD_W'(r_k),
        "running product and its next step disagree by more than k")
    `VDPC_ASSERT_IMPLY(a_prod_zero, r_pulse == '0, r_prod == '0,
        "running product nonzero with no pulses counted")
    `VDPC_ASSERT_NEXT(a_finish_stops, in_xfer && done, !r_pouring,
        "pump still running after reaching target")

endmodule
